### hw/rtl/cbpp_pkg.sv
package cbpp_pkg;

   localparam int COEF_W      = 32;
   localparam int COEF_COUNT  = 12;
   localparam int SRC_COUNT   = 3;
   localparam int MAT_BASE    = 3;
   localparam int MAT_COUNT   = 9;
   localparam int IDX_W       = 4;
   localparam int DIFF_W      = COEF_W + 1;
   localparam int PROD_W      = COEF_W + DIFF_W;
   localparam int DOT_W       = PROD_W + 2;
   localparam int MAG_W       = DOT_W - 1;
   localparam int QUO_W       = 32;
   localparam int STAT_W      = 2;
   localparam int FRAC_BITS_DEF = 16;

   localparam logic ACT_LOAD    = 1'b0;
   localparam logic ACT_PROJECT = 1'b1;

   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_ZERO = 2'd1;
   localparam logic [STAT_W-1:0] STAT_SAT  = 2'd2;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [DOT_W-1:0]  dot_type;

   // pipeline handshake between stage groups
   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctl_type;

endpackage

### hw/rtl/cone_beam_point_projector.sv
// Channel  | Dir | tdata (low bit up)                              | tuser
// req_     | in  | coef_index, coef_value, x_coord, y_coord, z_coord | action
// rsp_     | out | pixel_col, pixel_row                            | status
//
// One request per cycle while no response is held. A project request passes through
// 3 stages subtract/multiply/sum, 2 for magnitude and range check, 32 quotient
// steps of one bit each and one output register. Load requests give no response.
// Synchronous reset clears the coefficient table to zero and all valid bits.
// A held response stalls the whole pipeline through one common enable.
module cone_beam_point_projector import cbpp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [135:0]  req_tdata,  // coef_index, coef_value, x, y, z, zero pad
   input  logic          req_tuser,  // action
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [63:0]   rsp_tdata,  // pixel_col, pixel_row
   output logic [1:0]    rsp_tuser   // status
);

   coef_type        coef_ff [COEF_COUNT];
   logic            advance, accept;
   logic [IDX_W-1:0] idx;
   pipe_ctl_type    dot_ctl, div_ctl;
   logic            dot_valid;
   dot_type         dot_n [SRC_COUNT];
   logic signed [QUO_W-1:0] col, row;
   logic [STAT_W-1:0] stat;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;
   assign idx        = req_tdata[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COEF_COUNT; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (accept && req_tuser == ACT_LOAD && idx < IDX_W'(COEF_COUNT)) begin
         coef_ff[idx] <= req_tdata[IDX_W +: COEF_W];
      end
   end

   assign dot_ctl = '{advance: advance, valid: accept && req_tuser == ACT_PROJECT};
   assign div_ctl = '{advance: advance, valid: dot_valid};

   cbpp_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .ctl       (dot_ctl),
      .x_coord   (req_tdata[IDX_W + COEF_W +: COEF_W]),
      .y_coord   (req_tdata[IDX_W + 2*COEF_W +: COEF_W]),
      .z_coord   (req_tdata[IDX_W + 3*COEF_W +: COEF_W]),
      .coef      (coef_ff),
      .out_valid (dot_valid),
      .dot_out   (dot_n)
   );

   cbpp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dot_in    (dot_n),
      .out_valid (rsp_tvalid),
      .pixel_col (col),
      .pixel_row (row),
      .status    (stat)
   );

   assign rsp_tdata = {row, col};
   assign rsp_tuser = stat;

endmodule

### hw/rtl/cbpp_dot.sv
module cbpp_dot import cbpp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  pipe_ctl_type ctl,
   input  coef_type     x_coord,
   input  coef_type     y_coord,
   input  coef_type     z_coord,
   input  coef_type     coef [COEF_COUNT],
   output logic         out_valid,
   output dot_type      dot_out [SRC_COUNT]
);

   logic                     v1_ff, v2_ff, v3_ff;
   logic signed [DIFF_W-1:0] d_ff    [SRC_COUNT];
   coef_type                 mat1_ff [MAT_COUNT];
   logic signed [PROD_W-1:0] prod_ff [MAT_COUNT];
   dot_type                  n_ff    [SRC_COUNT];
   coef_type                 pt      [SRC_COUNT];

   assign pt[0] = x_coord;
   assign pt[1] = y_coord;
   assign pt[2] = z_coord;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (ctl.advance) begin
         v1_ff <= ctl.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // matrix is snapshotted with the point so later loads do not disturb it
   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         for (int k = 0; k < SRC_COUNT; k++) begin
            d_ff[k] <= DIFF_W'(pt[k]) - DIFF_W'(coef[k]);
         end
         for (int m = 0; m < MAT_COUNT; m++) begin
            mat1_ff[m] <= coef[MAT_BASE + m];
         end
         for (int j = 0; j < SRC_COUNT; j++) begin
            for (int k = 0; k < SRC_COUNT; k++) begin
               prod_ff[j*3 + k] <= PROD_W'(mat1_ff[j*3 + k]) * PROD_W'(d_ff[k]);
            end
         end
         for (int j = 0; j < SRC_COUNT; j++) begin
            n_ff[j] <= DOT_W'(prod_ff[j*3]) + DOT_W'(prod_ff[j*3 + 1])
                     + DOT_W'(prod_ff[j*3 + 2]);
         end
      end
   end

   assign out_valid = v3_ff;
   assign dot_out   = n_ff;

endmodule

### hw/rtl/cbpp_div.sv
module cbpp_div import cbpp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pipe_ctl_type             ctl,
   input  dot_type                  dot_in [SRC_COUNT],
   output logic                     out_valid,
   output logic signed [QUO_W-1:0]  pixel_col,
   output logic signed [QUO_W-1:0]  pixel_row,
   output logic [STAT_W-1:0]        status
);

   localparam int NUM_W = MAG_W + FRAC_BITS;
   localparam int LANES = 2;

   // stage A: magnitudes and signs
   logic             a_v_ff, a_zero_ff;
   logic [MAG_W-1:0] a_num_ff [LANES];
   logic [MAG_W-1:0] a_den_ff;
   logic             a_neg_ff [LANES];

   // division chain, index 0 is the range check stage
   logic             s_v_ff    [QUO_W+1];
   logic             s_zero_ff [QUO_W+1];
   logic [MAG_W-1:0] s_den_ff  [QUO_W+1];
   logic [MAG_W-1:0] s_rem_ff  [QUO_W+1][LANES];
   logic [QUO_W-1:0] s_low_ff  [QUO_W+1][LANES];
   logic [QUO_W-1:0] s_quo_ff  [QUO_W+1][LANES];
   logic             s_neg_ff  [QUO_W+1][LANES];
   logic             s_ov_ff   [QUO_W+1][LANES];

   logic [MAG_W-1:0] rem_in [QUO_W][LANES];
   logic             ge_in  [QUO_W][LANES];
   logic [MAG_W:0]   trial  [QUO_W][LANES];

   logic [NUM_W-1:0] num_sh [LANES];

   logic                    o_v_ff;
   logic signed [QUO_W-1:0] o_col_ff, o_row_ff;
   logic [STAT_W-1:0]       o_stat_ff;

   logic [QUO_W-1:0]        lim    [LANES];
   logic [QUO_W-1:0]        mag    [LANES];
   logic                    sat    [LANES];
   logic [QUO_W-1:0]        res_in [LANES];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         num_sh[l] = {a_num_ff[l], {FRAC_BITS{1'b0}}};
      end
      for (int s = 0; s < QUO_W; s++) begin
         for (int l = 0; l < LANES; l++) begin
            trial[s][l]  = {s_rem_ff[s][l], s_low_ff[s][l][QUO_W-1]};
            ge_in[s][l]  = trial[s][l] >= {1'b0, s_den_ff[s]};
            rem_in[s][l] = ge_in[s][l] ? MAG_W'(trial[s][l] - {1'b0, s_den_ff[s]})
                                       : MAG_W'(trial[s][l]);
         end
      end
      for (int l = 0; l < LANES; l++) begin
         lim[l]    = s_neg_ff[QUO_W][l] ? {1'b1, {(QUO_W-1){1'b0}}}
                                        : {1'b0, {(QUO_W-1){1'b1}}};
         sat[l]    = s_ov_ff[QUO_W][l] || (s_quo_ff[QUO_W][l] > lim[l]);
         mag[l]    = sat[l] ? lim[l] : s_quo_ff[QUO_W][l];
         res_in[l] = s_neg_ff[QUO_W][l] ? (~mag[l] + 1'b1) : mag[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
         for (int s = 0; s <= QUO_W; s++) begin
            s_v_ff[s] <= 1'b0;
         end
      end else if (ctl.advance) begin
         a_v_ff    <= ctl.valid;
         s_v_ff[0] <= a_v_ff;
         for (int s = 0; s < QUO_W; s++) begin
            s_v_ff[s+1] <= s_v_ff[s];
         end
         o_v_ff <= s_v_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         a_zero_ff <= (dot_in[2] == '0);
         a_den_ff  <= dot_in[2][DOT_W-1] ? MAG_W'(-dot_in[2]) : MAG_W'(dot_in[2]);
         for (int l = 0; l < LANES; l++) begin
            a_num_ff[l] <= dot_in[l][DOT_W-1] ? MAG_W'(-dot_in[l]) : MAG_W'(dot_in[l]);
            a_neg_ff[l] <= dot_in[l][DOT_W-1] ^ dot_in[2][DOT_W-1];
         end

         // quotient needs more than QUO_W bits when num >= den * 2^QUO_W
         s_zero_ff[0] <= a_zero_ff;
         s_den_ff[0]  <= a_den_ff;
         for (int l = 0; l < LANES; l++) begin
            s_ov_ff[0][l]  <= MAG_W'(num_sh[l][NUM_W-1:QUO_W]) >= a_den_ff;
            s_rem_ff[0][l] <= MAG_W'(num_sh[l][NUM_W-1:QUO_W]);
            s_low_ff[0][l] <= num_sh[l][QUO_W-1:0];
            s_quo_ff[0][l] <= '0;
            s_neg_ff[0][l] <= a_neg_ff[l];
         end

         for (int s = 0; s < QUO_W; s++) begin
            s_zero_ff[s+1] <= s_zero_ff[s];
            s_den_ff[s+1]  <= s_den_ff[s];
            for (int l = 0; l < LANES; l++) begin
               s_rem_ff[s+1][l] <= rem_in[s][l];
               s_low_ff[s+1][l] <= {s_low_ff[s][l][QUO_W-2:0], 1'b0};
               s_quo_ff[s+1][l] <= {s_quo_ff[s][l][QUO_W-2:0], ge_in[s][l]};
               s_neg_ff[s+1][l] <= s_neg_ff[s][l];
               s_ov_ff[s+1][l]  <= s_ov_ff[s][l];
            end
         end

         if (s_zero_ff[QUO_W]) begin
            o_col_ff  <= '0;
            o_row_ff  <= '0;
            o_stat_ff <= STAT_ZERO;
         end else begin
            o_col_ff  <= res_in[0];
            o_row_ff  <= res_in[1];
            o_stat_ff <= (sat[0] || sat[1]) ? STAT_SAT : STAT_OK;
         end
      end
   end

   assign out_valid = o_v_ff;
   assign pixel_col = o_col_ff;
   assign pixel_row = o_row_ff;
   assign status    = o_stat_ff;

endmodule
